// ===== rtl/bfbp_pkg.sv =====
// Shared types and constants of the best-fit buffer pool.
package bfbp_pkg;

    localparam int DATA_W   = 32;
    localparam int IDLE_W   = 16;
    localparam int OUT_CW   = 7;
    // rounded request width: one carry bit above the 32-bit size
    localparam int NEED_W   = DATA_W + 1;

    localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd1000;
    // created entries hold whole 4-byte elements
    localparam logic [DATA_W-1:0] ELEM_MASK  = 32'hFFFF_FFFC;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_START,
        OP_SCAN,
        OP_COMMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   kind;
    } t_dp_cmd;

    typedef struct packed {
        logic align_done;
        logic overflow;
        logic scan_done;
    } t_dp_status;

endpackage

// ===== rtl/bfbp_align.sv =====
// Round-up of a request to the alignment by reciprocal multiplication.
module bfbp_align
    import bfbp_pkg::*;
#(
    parameter int ALIGN_BYTES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_request,
    output logic              o_done,
    output logic [NEED_W-1:0] o_need
);

    // q = floor(x / ALIGN_BYTES) = (x * RCP) >> (NEED_W + SHIFT), exact for any x below
    // 2^NEED_W; the product is built from two 17-bit slices of RCP on successive cycles
    localparam int SHIFT  = $clog2(ALIGN_BYTES);
    localparam int HALF_W = 17;
    localparam int RCP_W  = 2 * HALF_W;
    localparam int PROD_W = NEED_W + HALF_W;
    localparam int Q_SH   = NEED_W + SHIFT - HALF_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << (NEED_W + SHIFT)) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [HALF_W-1:0] RCP_LO = RCP_FULL[HALF_W-1:0];
    localparam logic [HALF_W-1:0] RCP_HI = RCP_FULL[RCP_W-1:HALF_W];
    localparam logic [NEED_W-1:0] ADD_C  = NEED_W'(ALIGN_BYTES - 1);
    localparam logic [HALF_W-1:0] DIV_C  = HALF_W'(ALIGN_BYTES);

    logic [2:0]        r_stage;
    logic              r_done;
    logic [NEED_W-1:0] r_x;
    logic [NEED_W-1:0] r_lo_hi;
    logic [NEED_W-1:0] r_q;
    logic [NEED_W-1:0] r_need;

    logic [PROD_W-1:0] lo_prod;
    logic [PROD_W-1:0] hi_prod;
    logic [PROD_W:0]   q_sum;
    logic [PROD_W-1:0] need_prod;

    always_comb begin
        lo_prod   = PROD_W'(r_x) * PROD_W'(RCP_LO);
        hi_prod   = PROD_W'(r_x) * PROD_W'(RCP_HI);
        q_sum     = {1'b0, hi_prod} + (PROD_W + 1)'(r_lo_hi);
        need_prod = PROD_W'(r_q) * PROD_W'(DIV_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= {r_stage[1:0], i_start};
            r_done  <= r_stage[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= {1'b0, i_request} + ADD_C;
        end
        if (r_stage[0]) begin
            r_lo_hi <= NEED_W'(lo_prod >> HALF_W);
        end
        if (r_stage[1]) begin
            r_q <= NEED_W'(q_sum >> Q_SH);
        end
        if (r_stage[2]) begin
            // scale the quotient back up to land on the multiple
            r_need <= NEED_W'(need_prod);
        end
    end

    assign o_done = r_done;
    assign o_need = r_need;

endmodule

// ===== rtl/bfbp_datapath.sv =====
// Pool stores, rounding unit, scan and compaction datapath, result registers.
module bfbp_datapath
    import bfbp_pkg::*;
#(
    parameter int POOL_ENTRIES = 64,
    parameter int ALIGN_BYTES  = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [DATA_W-1:0] i_request_bytes,
    input  logic              i_cfg_wr_en,
    input  logic [IDLE_W-1:0] i_cfg_wr_data,
    output logic [DATA_W-1:0] o_buffer_handle,
    output logic [DATA_W-1:0] o_buffer_bytes,
    output logic              o_newly_created,
    output logic              o_pool_full,
    output logic [OUT_CW-1:0] o_evicted_count,
    output logic [OUT_CW-1:0] o_live_entries
);

    localparam int CW = $clog2(POOL_ENTRIES + 1);
    localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam logic [CW-1:0] POOL_C = CW'(POOL_ENTRIES);
    localparam logic [CW-1:0] ONE_C  = CW'(1);

    logic [DATA_W-1:0] mem_size [POOL_ENTRIES];
    logic [DATA_W-1:0] mem_last [POOL_ENTRIES];
    logic [DATA_W-1:0] mem_id   [POOL_ENTRIES];

    logic [DATA_W-1:0] r_rd_size;
    logic [DATA_W-1:0] r_rd_last;
    logic [DATA_W-1:0] r_rd_id;

    logic [DATA_W-1:0] r_frame;
    logic [DATA_W-1:0] r_next_id;
    logic [CW-1:0]     r_total;
    logic [IDLE_W-1:0] r_max_idle;
    logic              r_kind;
    logic              r_pend;
    logic [IW-1:0]     r_pend_idx;
    logic [CW-1:0]     r_rd_idx;
    logic [CW-1:0]     r_wr_idx;
    logic [CW-1:0]     r_evicted;
    logic              r_found;
    logic [IW-1:0]     r_best_idx;
    logic [DATA_W-1:0] r_best_size;
    logic [DATA_W-1:0] r_best_id;

    logic [DATA_W-1:0] r_o_handle;
    logic [DATA_W-1:0] r_o_bytes;
    logic              r_o_created;
    logic              r_o_full;
    logic [OUT_CW-1:0] r_o_evicted;
    logic [OUT_CW-1:0] r_o_live;

    logic              align_done;
    logic [NEED_W-1:0] need;
    logic              overflow;
    logic [DATA_W-1:0] new_size;
    logic [DATA_W-1:0] inc_id;

    logic              scanning;
    logic              issue;
    logic              scan_end;
    logic              eligible;
    logic              upd;
    logic              hit;
    logic [DATA_W-1:0] age;
    logic              stale;
    logic              keep_wr;
    logic              no_room;
    logic              create;
    logic              stamp;

    logic              we_size;
    logic              we_last;
    logic              we_id;
    logic [IW-1:0]     w_addr;
    logic [DATA_W-1:0] w_size;
    logic [DATA_W-1:0] w_last;
    logic [DATA_W-1:0] w_id;
    logic [IW-1:0]     rd_addr;

    logic [DATA_W-1:0] live_wide;
    logic [DATA_W-1:0] evict_wide;
    logic [CW-1:0]     n_live;

    bfbp_align #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_align (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   ((i_cmd.op == OP_START) && (i_cmd.kind == KIND_ALLOC)),
        .i_request (i_request_bytes),
        .o_done    (align_done),
        .o_need    (need)
    );

    assign overflow = need[NEED_W-1];
    assign new_size = need[DATA_W-1:0] & ELEM_MASK;
    assign inc_id   = r_next_id + DATA_W'(1);
    assign rd_addr  = r_rd_idx[IW-1:0];

    always_comb begin
        scanning = (i_cmd.op == OP_SCAN);
        issue    = scanning && (r_rd_idx < r_total);
        scan_end = !r_pend && (r_rd_idx >= r_total);
        eligible = (r_rd_last != r_frame) && ({1'b0, r_rd_size} >= need);
        upd      = scanning && r_pend && (r_kind == KIND_ALLOC) && eligible &&
                   (!r_found || (r_rd_size < r_best_size));
        hit      = upd && (r_rd_size == need[DATA_W-1:0]);
        age      = r_frame - r_rd_last;
        stale    = age > {{(DATA_W - IDLE_W){1'b0}}, r_max_idle};
        keep_wr  = scanning && r_pend && (r_kind == KIND_FRAME) && !stale;
        no_room  = overflow || (r_total >= POOL_C);
        stamp    = (i_cmd.op == OP_COMMIT) && (r_kind == KIND_ALLOC) && r_found;
        create   = (i_cmd.op == OP_COMMIT) && (r_kind == KIND_ALLOC) && !r_found &&
                   !no_room;
    end

    // one write port shared by compaction, stamping and creation
    always_comb begin
        we_size = 1'b0;
        we_last = 1'b0;
        we_id   = 1'b0;
        w_addr  = r_wr_idx[IW-1:0];
        w_size  = r_rd_size;
        w_last  = r_rd_last;
        w_id    = r_rd_id;
        if (keep_wr) begin
            we_size = 1'b1;
            we_last = 1'b1;
            we_id   = 1'b1;
        end else if (stamp) begin
            we_last = 1'b1;
            w_addr  = r_best_idx;
            w_last  = r_frame;
        end else if (create) begin
            we_size = 1'b1;
            we_last = 1'b1;
            we_id   = 1'b1;
            w_addr  = r_total[IW-1:0];
            w_size  = new_size;
            w_last  = r_frame;
            w_id    = r_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_size) begin
            mem_size[w_addr] <= w_size;
        end
        if (we_last) begin
            mem_last[w_addr] <= w_last;
        end
        if (we_id) begin
            mem_id[w_addr] <= w_id;
        end
        r_rd_size <= mem_size[rd_addr];
        r_rd_last <= mem_last[rd_addr];
        r_rd_id   <= mem_id[rd_addr];
    end

    always_comb begin
        if (r_kind == KIND_FRAME) begin
            n_live = r_wr_idx;
        end else if (create) begin
            n_live = r_total + ONE_C;
        end else begin
            n_live = r_total;
        end
        live_wide  = DATA_W'(n_live);
        evict_wide = DATA_W'(r_evicted);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame    <= '0;
            r_next_id  <= DATA_W'(1);
            r_total    <= '0;
            r_max_idle <= IDLE_RESET;
            r_kind     <= KIND_ALLOC;
            r_pend     <= 1'b0;
            r_rd_idx   <= '0;
            r_wr_idx   <= '0;
            r_evicted  <= '0;
            r_found    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_idle <= i_cfg_wr_data;
            end
            unique case (i_cmd.op)
                OP_START: begin
                    r_kind    <= i_cmd.kind;
                    r_pend    <= 1'b0;
                    r_rd_idx  <= '0;
                    r_wr_idx  <= '0;
                    r_evicted <= '0;
                    r_found   <= 1'b0;
                    if (i_cmd.kind == KIND_FRAME) begin
                        r_frame <= r_frame + DATA_W'(1);
                    end
                end
                OP_SCAN: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + ONE_C;
                    end
                    if (upd) begin
                        r_found <= 1'b1;
                    end
                    if (scanning && r_pend && (r_kind == KIND_FRAME)) begin
                        if (stale) begin
                            r_evicted <= r_evicted + ONE_C;
                        end else begin
                            r_wr_idx <= r_wr_idx + ONE_C;
                        end
                    end
                end
                OP_COMMIT: begin
                    r_total <= n_live;
                    if (create) begin
                        // handle zero never names an entry
                        r_next_id <= (inc_id == '0) ? DATA_W'(1) : inc_id;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_idx <= rd_addr;
        end
        if (upd) begin
            r_best_idx  <= r_pend_idx;
            r_best_size <= r_rd_size;
            r_best_id   <= r_rd_id;
        end
        if (i_cmd.op == OP_COMMIT) begin
            r_o_handle  <= '0;
            r_o_bytes   <= '0;
            r_o_created <= 1'b0;
            r_o_full    <= 1'b0;
            r_o_evicted <= '0;
            r_o_live    <= live_wide[OUT_CW-1:0];
            if (r_kind == KIND_FRAME) begin
                r_o_evicted <= evict_wide[OUT_CW-1:0];
            end else if (r_found) begin
                r_o_handle <= r_best_id;
                r_o_bytes  <= r_best_size;
            end else if (no_room) begin
                r_o_full <= 1'b1;
            end else begin
                r_o_handle  <= r_next_id;
                r_o_bytes   <= new_size;
                r_o_created <= 1'b1;
            end
        end
    end

    assign o_status.align_done = align_done;
    assign o_status.overflow   = overflow;
    assign o_status.scan_done  = scan_end || hit;

    assign o_buffer_handle = r_o_handle;
    assign o_buffer_bytes  = r_o_bytes;
    assign o_newly_created = r_o_created;
    assign o_pool_full     = r_o_full;
    assign o_evicted_count = r_o_evicted;
    assign o_live_entries  = r_o_live;

endmodule

// ===== rtl/bfbp_ctrl.sv =====
// Sequencer: accepts a beat, steps rounding, scan and commit, owns output valid.
module bfbp_ctrl
    import bfbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.kind  = i_kind;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_START;
                    n_state  = (i_kind == KIND_FRAME) ? S_SCAN : S_ROUND;
                end
            end
            S_ROUND: begin
                if (i_status.align_done) begin
                    n_state = i_status.overflow ? S_COMMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_status.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    o_cmd.op    = OP_COMMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/best_fit_buffer_pool_unit.sv =====
// Top level of the best-fit buffer pool: sequencer plus pool datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_kind, i_request_bytes
//  out     | output    | o_out_valid / i_out_stall | o_buffer_handle, o_buffer_bytes,
//          |           |                           | o_newly_created, o_pool_full,
//          |           |                           | o_evicted_count, o_live_entries
//  cfg     | input     | i_cfg_wr_en               | i_cfg_wr_data (max idle frames)
//
// One beat in flight. An allocate steps through the accept, rounding of the request by
// reciprocal multiply, a scan through the registered pool read, and one commit; an exact
// fit ends the scan early and an oversize request skips it. A frame beat skips the rounding.
// Reset clears control state only; only entries below the live count are ever used.
// A finished result waits in the output register while the next beat is taken; that
// beat's commit holds until the register drains.
module best_fit_buffer_pool_unit
    import bfbp_pkg::*;
#(
    parameter int POOL_ENTRIES = 64,
    parameter int ALIGN_BYTES  = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input beat
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [DATA_W-1:0] i_request_bytes,
    // result beat
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_buffer_handle,
    output logic [DATA_W-1:0] o_buffer_bytes,
    output logic              o_newly_created,
    output logic              o_pool_full,
    output logic [OUT_CW-1:0] o_evicted_count,
    output logic [OUT_CW-1:0] o_live_entries,
    // idle limit register
    input  logic              i_cfg_wr_en,
    input  logic [IDLE_W-1:0] i_cfg_wr_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer: hold the input while busy, advance through round, scan, commit
    bfbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // pool stores, best-fit search, eviction with in-order compaction
    bfbp_datapath #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .ALIGN_BYTES  (ALIGN_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_request_bytes (i_request_bytes),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_buffer_handle (o_buffer_handle),
        .o_buffer_bytes  (o_buffer_bytes),
        .o_newly_created (o_newly_created),
        .o_pool_full     (o_pool_full),
        .o_evicted_count (o_evicted_count),
        .o_live_entries  (o_live_entries)
    );

endmodule

// ===== sim/tb_best_fit_buffer_pool_unit.sv =====
// Self-checking testbench of the best-fit buffer pool unit.
module tb_best_fit_buffer_pool_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import bfbp_pkg::*;

    localparam int POOL_DEPTH   = 64;
    localparam int ALIGN        = 1024;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    // Slowest clean run is roughly 1400 beats.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // One frame beat over a full pool plus an allocate behind it.
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_SHOWN    = 10;
    localparam int GAP_MAX      = 13;

    // One result beat, in port order.
    typedef struct packed {
        logic [DATA_W-1:0] handle;
        logic [DATA_W-1:0] bytes;
        logic              created;
        logic              full;
        logic [OUT_CW-1:0] evicted;
        logic [OUT_CW-1:0] live;
    } t_grant;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              in_kind;
    logic [DATA_W-1:0] in_request;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] out_handle;
    logic [DATA_W-1:0] out_bytes;
    logic              out_created;
    logic              out_full;
    logic [OUT_CW-1:0] out_evicted;
    logic [OUT_CW-1:0] out_live;
    logic              cfg_wr_en;
    logic [IDLE_W-1:0] cfg_wr_data;

    best_fit_buffer_pool_unit #(
        .POOL_ENTRIES (POOL_DEPTH),
        .ALIGN_BYTES  (ALIGN)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_kind          (in_kind),
        .i_request_bytes (in_request),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_buffer_handle (out_handle),
        .o_buffer_bytes  (out_bytes),
        .o_newly_created (out_created),
        .o_pool_full     (out_full),
        .o_evicted_count (out_evicted),
        .o_live_entries  (out_live),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    // Shadow copy of the pool, kept in insertion order like the block.
    logic [DATA_W-1:0] pool_size   [POOL_DEPTH];
    logic [DATA_W-1:0] pool_stamp  [POOL_DEPTH];
    logic [DATA_W-1:0] pool_handle [POOL_DEPTH];
    int                pool_count;
    logic [DATA_W-1:0] frame_no;
    logic [DATA_W-1:0] next_handle;
    logic [IDLE_W-1:0] idle_limit;

    // Grants predicted at input acceptance, oldest first.
    t_grant pending_grants[$];

    // Idle knobs of the sender and the receiver process.
    int sender_gap_max   = GAP_MAX;
    int receiver_gap_max = GAP_MAX;
    bit hold_request     = 1'b0;

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int alloc_beats     = 0;
    int frame_beats     = 0;
    int created_beats   = 0;
    int reused_beats    = 0;
    int refused_beats   = 0;
    int evicted_entries = 0;
    int limit_writes    = 0;
    int holds_done      = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Abort a hung run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d grants outstanding",
                 cycle_count, pending_grants.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void reset_predictor();
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_size[i]   = '0;
            pool_stamp[i]  = '0;
            pool_handle[i] = '0;
        end
        pool_count  = 0;
        frame_no    = '0;
        next_handle = 32'd1;
        idle_limit  = IDLE_RESET;
    endfunction

    // Apply one beat to the shadow pool and return the grant it yields.
    function automatic t_grant predict_grant(input logic kind, input logic [DATA_W-1:0] req);
        t_grant            g;
        logic [63:0]       need;
        logic [DATA_W-1:0] want;
        logic [DATA_W-1:0] age;
        logic              found;
        int                best;
        int                wr;
        g = '0;
        if (kind == KIND_FRAME) begin
            // Advance the frame, then compact survivors toward index 0.
            frame_no = frame_no + 1;
            wr = 0;
            for (int rd = 0; rd < pool_count; rd++) begin
                age = frame_no - pool_stamp[rd];
                if (age > DATA_W'(idle_limit)) begin
                    g.evicted = g.evicted + 1'b1;
                end else begin
                    pool_size[wr]   = pool_size[rd];
                    pool_stamp[wr]  = pool_stamp[rd];
                    pool_handle[wr] = pool_handle[rd];
                    wr++;
                end
            end
            pool_count = wr;
        end else begin
            need = ((64'(req) + ALIGN - 1) / ALIGN) * ALIGN;
            if (need > 64'hFFFF_FFFF) begin
                // Rounded size overflows 32 bits: nothing can match.
                g.full = 1'b1;
            end else begin
                want  = need[DATA_W-1:0];
                found = 1'b0;
                best  = 0;
                for (int i = 0; i < pool_count; i++) begin
                    if (pool_stamp[i] == frame_no || pool_size[i] < want) continue;
                    if (!found || pool_size[i] < pool_size[best]) begin
                        found = 1'b1;
                        best  = i;
                        if (pool_size[i] == want) break;
                    end
                end
                if (found) begin
                    pool_stamp[best] = frame_no;
                    g.handle = pool_handle[best];
                    g.bytes  = pool_size[best];
                end else if (pool_count >= POOL_DEPTH) begin
                    g.full = 1'b1;
                end else begin
                    pool_size[pool_count]   = want & ELEM_MASK;
                    pool_stamp[pool_count]  = frame_no;
                    pool_handle[pool_count] = next_handle;
                    g.handle  = next_handle;
                    g.bytes   = want & ELEM_MASK;
                    g.created = 1'b1;
                    // Skip handle 0 on wrap.
                    next_handle = next_handle + 1;
                    if (next_handle == '0) next_handle = 32'd1;
                    pool_count++;
                end
            end
        end
        g.live = OUT_CW'(pool_count);
        return g;
    endfunction

    // Offer one input beat after a random gap; hold it until accepted.
    task automatic send_beat(input logic kind, input logic [DATA_W-1:0] req);
        int     gap;
        t_grant g;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_kind    <= kind;
        in_request <= req;
        in_valid   <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        g = predict_grant(kind, req);
        pending_grants.insert(pending_grants.size(), g);
        if (kind == KIND_FRAME) begin
            frame_beats++;
            evicted_entries += g.evicted;
        end else begin
            alloc_beats++;
            if (g.created) created_beats++;
            else if (g.full) refused_beats++;
            else reused_beats++;
        end
    endtask

    // Write the idle limit with the block drained and the input quiet.
    task automatic write_idle_limit(input logic [IDLE_W-1:0] limit);
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        idle_limit = limit;
        limit_writes++;
    endtask

    // Random beat: mostly allocates from a few size classes so entries get reused.
    task automatic send_random_item(input int frame_pct);
        logic [DATA_W-1:0] req;
        int                pick;
        if ($urandom_range(0, 99) < frame_pct) begin
            // Request field is don't-care on a frame beat; toggle it anyway.
            send_beat(KIND_FRAME, $urandom());
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                req = ($urandom_range(0, 7) << 10)
                      - (($urandom_range(0, 1) == 1) ? $urandom_range(0, 1023) : 0);
            else if (pick < 80)
                req = $urandom_range(0, 1 << 20);
            else if (pick < 92)
                req = $urandom();
            else if (pick < 96)
                req = 32'h8000_0000 - 32'd2048 + $urandom_range(0, 4096);
            else
                req = 32'hFFFF_F800 + $urandom_range(0, 2047);
            send_beat(KIND_ALLOC, req);
        end
    endtask

    task automatic run_phase(input logic [IDLE_W-1:0] limit, input int items,
                             input int frame_pct, input int sgap, input int rgap);
        write_idle_limit(limit);
        sender_gap_max   = sgap;
        receiver_gap_max = rgap;
        repeat (items) send_random_item(frame_pct);
        sender_gap_max   = GAP_MAX;
        receiver_gap_max = GAP_MAX;
    endtask

    // Rounding, best fit, tie order, exact fit, one grant per frame, oversize.
    task automatic test_directed_grants();
        send_beat(KIND_ALLOC, 32'd0);            // zero size entry
        send_beat(KIND_ALLOC, 32'd1);            // rounds up to one block
        send_beat(KIND_ALLOC, 32'd1024);         // same size, first one already used
        send_beat(KIND_ALLOC, 32'h8000_0000);
        send_beat(KIND_ALLOC, 32'hFFFF_FC00);    // largest size that rounds in range
        send_beat(KIND_ALLOC, 32'hFFFF_FFFF);    // overflows on rounding
        send_beat(KIND_ALLOC, 32'hFFFF_FC01);
        send_beat(KIND_FRAME, 32'd0);
        send_beat(KIND_ALLOC, 32'd0);            // exact fit on the zero entry
        send_beat(KIND_ALLOC, 32'd1000);         // tie, earliest wins
        send_beat(KIND_ALLOC, 32'd1500);         // smallest sufficient entry
        send_beat(KIND_ALLOC, 32'd700);
        send_beat(KIND_ALLOC, 32'd1);            // only the largest is left
        send_beat(KIND_ALLOC, 32'd1);            // all used this frame: append
        send_beat(KIND_FRAME, 32'hFFFF_FFFF);
    endtask

    // Walk the idle limit through both extremes and a small value.
    task automatic test_idle_limit_extremes();
        write_idle_limit(16'hFFFF);
        send_beat(KIND_ALLOC, 32'd5000);
        send_beat(KIND_FRAME, 32'd0);
        send_beat(KIND_FRAME, 32'd0);
        write_idle_limit(16'd1);
        send_beat(KIND_FRAME, 32'd0);
        send_beat(KIND_ALLOC, 32'd2048);
        send_beat(KIND_FRAME, 32'd0);
        write_idle_limit(16'd0);
        send_beat(KIND_FRAME, 32'd0);            // drop everything idle
    endtask

    // Fill the store within one frame, overrun it, then evict it all at once.
    task automatic test_pool_exhaustion();
        write_idle_limit(16'd0);
        send_beat(KIND_FRAME, 32'd0);
        repeat (POOL_DEPTH + 4) send_beat(KIND_ALLOC, $urandom_range(0, 1 << 16));
        send_beat(KIND_FRAME, $urandom());
        write_idle_limit(IDLE_RESET);
    endtask

    // Bulk random traffic over several idle limits and idle profiles.
    task automatic test_random_mix();
        run_phase(16'd2,     300, 12, GAP_MAX, GAP_MAX);
        run_phase(16'd0,     150, 10, 0,       0);        // back to back, no idling
        run_phase(16'hFFFF,  200, 5,  GAP_MAX, GAP_MAX);  // pool fills up
        run_phase(16'($urandom_range(0, 8)), 250, 15, GAP_MAX, GAP_MAX);
        run_phase(16'd1,     150, 20, 0,       GAP_MAX);
        run_phase(16'($urandom_range(0, 16'hFFFF)), 150, 8, GAP_MAX, 0);
    endtask

    // Hold the output off for a long stretch while the sender keeps pushing.
    task automatic test_output_backpressure();
        write_idle_limit(16'd3);
        sender_gap_max   = 0;
        receiver_gap_max = 0;
        hold_request     = 1'b1;
        repeat (40) send_random_item(10);
        sender_gap_max   = GAP_MAX;
        receiver_gap_max = GAP_MAX;
    endtask

    // Receiver: random stall per result beat, plus the long hold on request.
    initial begin : drive_out_stall
        int wait_n;
        out_stall = 1'b0;
        forever begin
            if (hold_request) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
                holds_done++;
            end
            wait_n = $urandom_range(0, receiver_gap_max);
            if (wait_n > 0) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
                repeat (wait_n - 1) @(negedge i_clk);
                @(negedge i_clk);
                out_stall <= 1'b0;
            end
            do begin
                @(posedge i_clk);
            end while (!(out_valid && !out_stall));
        end
    end

    // Compare every accepted result beat against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_grant want;
        t_grant got;
        if (i_rst_n && out_valid && !out_stall) begin
            got = {out_handle, out_bytes, out_created, out_full, out_evicted, out_live};
            if (pending_grants.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("%0t: unexpected result beat handle=%h bytes=%h",
                             $realtime, got.handle, got.bytes);
            end else begin
                want = pending_grants.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display({"%0t: mismatch handle %h/%h bytes %h/%h created %b/%b ",
                                  "full %b/%b evicted %0d/%0d live %0d/%0d (exp/act)"},
                                 $realtime, want.handle, got.handle, want.bytes, got.bytes,
                                 want.created, got.created, want.full, got.full,
                                 want.evicted, got.evicted, want.live, got.live);
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_kind     = KIND_ALLOC;
        in_request  = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        reset_predictor();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_grants();
        test_idle_limit_extremes();
        test_pool_exhaustion();
        test_random_mix();
        test_output_backpressure();

        // Drop valid, drain what is in flight, then let the block settle.
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_grants.size() != 0) begin
            mismatch_count++;
            $display("%0d predicted grants never arrived", pending_grants.size());
        end

        $display("Ran %0d allocate beats (%0d created, %0d reused, %0d refused) and %0d frames",
                 alloc_beats, created_beats, reused_beats, refused_beats, frame_beats);
        $display("evicting %0d entries, over %0d idle limit writes and %0d long output holds",
                 evicted_entries, limit_writes, holds_done);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d failing result beats", mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bfbp_pkg.sv
rtl/bfbp_align.sv
rtl/bfbp_datapath.sv
rtl/bfbp_ctrl.sv
rtl/best_fit_buffer_pool_unit.sv
sim/tb_best_fit_buffer_pool_unit.sv
